// File: rtl/motor_session_timer_controller_defines.svh
// Assertion macros for the motor session timer controller.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef MOTOR_SESSION_TIMER_CONTROLLER_DEFINES_SVH
`define MOTOR_SESSION_TIMER_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/msc_pkg.sv
// Types, codes and constants shared by the motor session timer controller.
// No dependencies.
package msc_pkg;

    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_ON    = 3'd1;
    localparam logic [2:0] KIND_PLUS  = 3'd2;
    localparam logic [2:0] KIND_MINUS = 3'd3;
    localparam logic [2:0] KIND_PWM   = 3'd4;

    localparam logic [2:0] CFG_MIN_WORK   = 3'd0;
    localparam logic [2:0] CFG_MAX_WORK   = 3'd1;
    localparam logic [2:0] CFG_DIM_TICKS  = 3'd2;
    localparam logic [2:0] CFG_OFF_TICKS  = 3'd3;
    localparam logic [2:0] CFG_RAMP_STEP  = 3'd4;
    localparam logic [2:0] CFG_USES_START = 3'd5;

    localparam int PB_ON    = 0;
    localparam int PB_PLUS  = 1;
    localparam int PB_MINUS = 2;
    localparam int PB_ANY   = 3;

    localparam logic [1:0]  LOCKOUT       = 2'd3;
    localparam logic [13:0] DUTY_TOP      = 14'd10000;
    localparam logic [15:0] WORK_STEP     = 16'd10;
    localparam logic [4:0]  TICKS_PER_SEC = 5'd9;
    localparam logic [3:0]  DIM_REPEATS   = 4'd9;
    localparam logic [7:0]  PAUSE_HOLD    = 8'd5;
    localparam logic [7:0]  RESUME_HOLD   = 8'd3;
    localparam logic [15:0] BAND_LOW      = 16'd10;
    localparam logic [15:0] BAND_MID      = 16'd30;

    localparam logic [1:0] BAND_IDLE  = 2'd0;
    localparam logic [1:0] BAND_SHORT = 2'd1;
    localparam logic [1:0] BAND_MEDIUM = 2'd2;
    localparam logic [1:0] BAND_LONG  = 2'd3;

    localparam logic [15:0] MIN_WORK_RST   = 16'd60;
    localparam logic [15:0] MAX_WORK_RST   = 16'd600;
    localparam logic [15:0] DIM_TICKS_RST  = 16'd600;
    localparam logic [15:0] OFF_TICKS_RST  = 16'd3000;
    localparam logic [9:0]  RAMP_STEP_RST  = 10'd10;
    localparam logic [15:0] USES_START_RST = 16'd100;

    typedef struct packed {
        logic active;
        logic paused;
        logic dimmed;
        logic set_pause;
        logic clr_pause;
    } msc_flags_t;

    typedef struct packed {
        logic [2:0][1:0] lock;
        logic [3:0]      pend;
        logic [3:0]      tick_div;
        logic            sec_flag;
        logic [15:0]     work;
        logic [15:0]     saved_work;
        msc_flags_t      flags;
        logic [7:0]      hold;
        logic [13:0]     duty;
        logic            motor_run;
        logic            powered_off;
        logic [15:0]     uses;
        logic [15:0]     dim_cnt;
        logic [15:0]     off_cnt;
        logic [3:0]      dim_rep;
    } msc_state_t;

    typedef struct packed {
        logic [15:0] min_work;
        logic [15:0] max_work;
        logic [15:0] dim_ticks;
        logic [15:0] off_ticks;
        logic [9:0]  ramp_step;
    } msc_cfg_t;

    typedef struct packed {
        logic [13:0] motor_duty;
        logic        motor_on;
        logic [15:0] work_seconds;
        logic        session_active;
        logic        session_paused;
        logic        dimmed;
        logic        power_off;
        logic [15:0] uses_left;
        logic [1:0]  time_band;
        logic        store_uses;
    } msc_result_t;

endpackage

// File: rtl/msc_if.sv
// Valid/ready channel interfaces for events in and results out.
// Depends on nothing; field widths follow the controller's item formats.
interface msc_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic       on_held;

    modport source (output valid, kind, on_held, input ready);
    modport sink   (input valid, kind, on_held, output ready);
endinterface

interface msc_res_if;
    logic        valid;
    logic        ready;
    logic [13:0] motor_duty;
    logic        motor_on;
    logic [15:0] work_seconds;
    logic        session_active;
    logic        session_paused;
    logic        dimmed;
    logic        power_off;
    logic [15:0] uses_left;
    logic [1:0]  time_band;
    logic        store_uses;

    modport source (output valid, motor_duty, motor_on, work_seconds, session_active,
                    session_paused, dimmed, power_off, uses_left, time_band, store_uses,
                    input ready);
    modport sink   (input valid, motor_duty, motor_on, work_seconds, session_active,
                    session_paused, dimmed, power_off, uses_left, time_band, store_uses,
                    output ready);
endinterface

// File: rtl/msc_step.sv
// Next-state and result logic for one event of the session timer controller.
// Depends on msc_pkg.
module msc_step
    import msc_pkg::*;
(
    input  msc_state_t  cur,
    input  msc_cfg_t    cfg,
    input  logic [2:0]  kind,
    input  logic        on_held,
    output msc_state_t  nxt,
    output msc_result_t result
);

    msc_state_t  s;
    logic        expired;
    logic        store_now;
    logic [1:0]  bidx;
    logic [4:0]  tdiv_inc;
    logic [1:0]  band;

    always_comb
    begin
        s         = cur;
        expired   = 1'b0;
        store_now = 1'b0;
        bidx      = kind[1:0] - 2'd1;
        tdiv_inc  = {1'b0, cur.tick_div} + 5'd1;

        if (!cur.powered_off)
        begin
            unique case (kind)
                KIND_TICK:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (s.lock[i] != 2'd0)
                            s.lock[i] = s.lock[i] - 2'd1;
                    end
                    s.tick_div = tdiv_inc[3:0];
                    if (tdiv_inc > TICKS_PER_SEC)
                    begin
                        s.sec_flag = 1'b1;
                        s.tick_div = 4'd0;
                    end

                    if (s.dim_cnt != 16'd0)
                        s.dim_cnt = s.dim_cnt - 16'd1;
                    else
                    begin
                        s.dim_rep = s.dim_rep + 4'd1;
                        if (s.dim_rep > DIM_REPEATS)
                        begin
                            s.dim_rep      = 4'd0;
                            s.flags.dimmed = 1'b1;
                        end
                    end

                    if (s.off_cnt != 16'd0)
                        s.off_cnt = s.off_cnt - 16'd1;
                    else
                        s.powered_off = 1'b1;

                    if (!s.powered_off)
                    begin
                        if (s.flags.active)
                        begin
                            if (s.sec_flag)
                            begin
                                if (s.motor_run)
                                begin
                                    s.work = s.work - 16'd1;
                                    if (s.work == 16'd0)
                                    begin
                                        s.flags.active = 1'b0;
                                        s.flags.paused = 1'b0;
                                        expired        = 1'b1;
                                    end
                                    else
                                    begin
                                        s.dim_cnt      = cfg.dim_ticks;
                                        s.off_cnt      = cfg.off_ticks;
                                        s.flags.dimmed = 1'b0;
                                    end
                                end
                                s.sec_flag = 1'b0;
                            end
                            if (on_held)
                            begin
                                s.hold = s.hold + 8'd1;
                                if (!s.flags.paused)
                                begin
                                    if (s.hold == PAUSE_HOLD)
                                    begin
                                        s.flags.set_pause = 1'b1;
                                        s.flags.clr_pause = 1'b0;
                                        s.duty            = 14'd0;
                                        s.motor_run       = 1'b0;
                                        s.pend            = 4'd0;
                                    end
                                end
                                else if (s.hold == RESUME_HOLD)
                                begin
                                    s.flags.clr_pause = 1'b1;
                                    s.flags.set_pause = 1'b0;
                                    s.motor_run       = 1'b1;
                                    s.duty            = 14'd0;
                                end
                            end
                            else
                            begin
                                s.hold = 8'd0;
                                if (s.flags.set_pause)
                                    s.flags.paused = 1'b1;
                                if (s.flags.clr_pause)
                                    s.flags.paused = 1'b0;
                                s.flags.set_pause = 1'b0;
                                s.flags.clr_pause = 1'b0;
                            end
                        end

                        if (s.pend[PB_ANY])
                        begin
                            if (s.flags.dimmed)
                            begin
                                if (s.pend[PB_PLUS] || s.pend[PB_MINUS])
                                begin
                                    s.dim_cnt      = cfg.dim_ticks;
                                    s.off_cnt      = cfg.off_ticks;
                                    s.pend         = 4'd0;
                                    s.flags.dimmed = 1'b0;
                                end
                            end
                            else
                            begin
                                if (s.pend[PB_PLUS] && (s.work < cfg.max_work))
                                begin
                                    s.work          = s.work + WORK_STEP;
                                    s.flags.dimmed  = 1'b0;
                                    s.pend[PB_PLUS] = 1'b0;
                                end
                                if (s.pend[PB_MINUS] && (s.work > cfg.min_work))
                                begin
                                    s.work           = s.work - WORK_STEP;
                                    s.flags.dimmed   = 1'b0;
                                    s.pend[PB_MINUS] = 1'b0;
                                end
                                if (s.pend[PB_ON])
                                begin
                                    if (!s.flags.active)
                                    begin
                                        if (s.uses != 16'd0)
                                            s.uses = s.uses - 16'd1;
                                        if (s.uses != 16'd0)
                                        begin
                                            store_now      = 1'b1;
                                            s.tick_div     = 4'd0;
                                            s.flags.active = 1'b1;
                                            s.saved_work   = s.work;
                                            s.sec_flag     = 1'b0;
                                            s.motor_run    = 1'b1;
                                            s.duty         = 14'd0;
                                        end
                                        s.flags.dimmed = 1'b0;
                                    end
                                    s.pend[PB_ON] = 1'b0;
                                end
                                s.dim_cnt = cfg.dim_ticks;
                                s.off_cnt = cfg.off_ticks;
                            end
                            s.pend[PB_ANY] = 1'b0;
                        end

                        if (expired)
                        begin
                            s.work         = s.saved_work;
                            s.dim_cnt      = cfg.dim_ticks;
                            s.off_cnt      = cfg.off_ticks;
                            s.flags.dimmed = 1'b0;
                            s.duty         = 14'd0;
                            s.motor_run    = 1'b0;
                            s.pend         = 4'd0;
                        end
                    end
                end
                KIND_ON, KIND_PLUS, KIND_MINUS:
                begin
                    if (!s.motor_run
                        && ((bidx == 2'd0) ? !s.flags.dimmed
                                           : (s.flags.dimmed || !s.flags.active))
                        && (s.lock[bidx] == 2'd0))
                    begin
                        s.pend[bidx]   = 1'b1;
                        s.pend[PB_ANY] = 1'b1;
                        s.lock[bidx]   = LOCKOUT;
                    end
                end
                KIND_PWM:
                begin
                    if (s.motor_run && (s.duty <= DUTY_TOP))
                        s.duty = s.duty + {4'd0, cfg.ramp_step};
                end
                default:
                begin
                end
            endcase
        end

        priority if (!s.flags.active)
            band = BAND_IDLE;
        else if (s.work < BAND_LOW)
            band = BAND_SHORT;
        else if (s.work < BAND_MID)
            band = BAND_MEDIUM;
        else
            band = BAND_LONG;

        nxt                   = s;
        result.motor_duty     = s.duty;
        result.motor_on       = s.motor_run;
        result.work_seconds   = s.work;
        result.session_active = s.flags.active;
        result.session_paused = s.flags.paused;
        result.dimmed         = s.flags.dimmed;
        result.power_off      = s.powered_off;
        result.uses_left      = s.uses;
        result.time_band      = band;
        result.store_uses     = store_now;
    end

endmodule

// File: rtl/motor_session_timer_controller.sv
// Top level of the motor session timer controller: state, settings and result register.
// Depends on msc_pkg, msc_if.sv, msc_step and the assertion macro header.
//
// Takes one event (tick, button edge or PWM period) per clock and returns exactly one
// result for it, registered in the cycle after the transfer. The event channel is ready
// whenever the result register is empty or its result is taken in the same cycle, so
// with a ready consumer the sustained rate is one event per cycle; the session state
// update is a single pass of logic from the state register to its next value. Settings
// must be written via the cfg port only while no event is in flight, which the block
// does not enforce; writing the minimum, dim, off or uses setting reloads its counter.
`include "motor_session_timer_controller_defines.svh"

module motor_session_timer_controller
    import msc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    msc_evt_if.sink      evt,
    msc_res_if.source    res
);

    msc_state_t  st_reg;
    msc_state_t  st_next;
    msc_cfg_t    cfg_reg;
    msc_result_t res_reg;
    msc_result_t res_next;
    logic        res_valid_reg;
    logic        evt_xfer;

    assign evt.ready = !res_valid_reg || res.ready;
    assign evt_xfer  = evt.valid && evt.ready;

    msc_step u_step (
        .cur     (st_reg),
        .cfg     (cfg_reg),
        .kind    (evt.kind),
        .on_held (evt.on_held),
        .nxt     (st_next),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_work  <= MIN_WORK_RST;
            cfg_reg.max_work  <= MAX_WORK_RST;
            cfg_reg.dim_ticks <= DIM_TICKS_RST;
            cfg_reg.off_ticks <= OFF_TICKS_RST;
            cfg_reg.ramp_step <= RAMP_STEP_RST;
            st_reg            <= '{work:    MIN_WORK_RST,
                                   uses:    USES_START_RST,
                                   dim_cnt: DIM_TICKS_RST,
                                   off_cnt: OFF_TICKS_RST,
                                   default: '0};
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_MIN_WORK:
                    begin
                        cfg_reg.min_work <= cfg_wdata;
                        st_reg.work      <= cfg_wdata;
                    end
                    CFG_MAX_WORK:
                        cfg_reg.max_work <= cfg_wdata;
                    CFG_DIM_TICKS:
                    begin
                        cfg_reg.dim_ticks <= cfg_wdata;
                        st_reg.dim_cnt    <= cfg_wdata;
                    end
                    CFG_OFF_TICKS:
                    begin
                        cfg_reg.off_ticks <= cfg_wdata;
                        st_reg.off_cnt    <= cfg_wdata;
                    end
                    CFG_RAMP_STEP:
                        cfg_reg.ramp_step <= cfg_wdata[9:0];
                    CFG_USES_START:
                        st_reg.uses <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            else if (evt_xfer)
                st_reg <= st_next;

            if (evt_xfer)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_xfer)
            res_reg <= res_next;
    end

    assign res.valid          = res_valid_reg;
    assign res.motor_duty     = res_reg.motor_duty;
    assign res.motor_on       = res_reg.motor_on;
    assign res.work_seconds   = res_reg.work_seconds;
    assign res.session_active = res_reg.session_active;
    assign res.session_paused = res_reg.session_paused;
    assign res.dimmed         = res_reg.dimmed;
    assign res.power_off      = res_reg.power_off;
    assign res.uses_left      = res_reg.uses_left;
    assign res.time_band      = res_reg.time_band;
    assign res.store_uses     = res_reg.store_uses;

    `MSC_ASSERT_NEXT(a_off_latched, st_reg.powered_off, st_reg.powered_off, "power-off dropped")
    `MSC_ASSERT_NOW(a_motor_in_session, st_reg.motor_run, st_reg.flags.active, "motor outside session")
    `MSC_ASSERT_NOW(a_duty_idle, !st_reg.motor_run, st_reg.duty == 14'd0, "duty left while stopped")
    `MSC_ASSERT_NOW(a_no_overrun, res_valid_reg && !res.ready, !evt.ready, "result overwritten")

endmodule
